### rtl/core/pmtfs_pkg.sv
// Shared types, widths and state encodings of the patch max-trace feature selector.
package pmtfs_pkg;

    // Field widths fixed by the stream format.
    localparam int PATCH_BITS      = 9;
    localparam int COORD_BITS      = 12;
    localparam int TENSOR_BITS     = 24;
    localparam int TRACE_BITS      = TENSOR_BITS + 1;
    localparam int DEF_MAX_PATCHES = 512;

    // Eigenvalue datapath widths.
    localparam int SQ_BITS        = 2 * TENSOR_BITS;
    localparam int DISC_BITS      = SQ_BITS + 3;
    localparam int ROOT_BITS      = (DISC_BITS + 1) / 2;
    localparam int RAD_BITS       = 2 * ROOT_BITS;
    localparam int REM_BITS       = ROOT_BITS + 2;
    localparam int ROOT_CNT_BITS  = $clog2(ROOT_BITS);

    // Input request: one pixel with its tensor.
    typedef struct packed {
        logic [PATCH_BITS-1:0]         patch_number;
        logic [COORD_BITS-1:0]         pixel_x;
        logic [COORD_BITS-1:0]         pixel_y;
        logic [TENSOR_BITS-1:0]        tensor_xx;
        logic signed [TENSOR_BITS-1:0] tensor_xy;
        logic [TENSOR_BITS-1:0]        tensor_yy;
        logic                          first_of_patch;
        logic                          last_of_patch;
    } pmtfs_in_t;

    // Result request: the best point of one patch.
    typedef struct packed {
        logic [PATCH_BITS-1:0]         out_patch;
        logic [COORD_BITS-1:0]         point_x;
        logic [COORD_BITS-1:0]         point_y;
        logic [TENSOR_BITS-1:0]        best_xx;
        logic signed [TENSOR_BITS-1:0] best_xy;
        logic [TENSOR_BITS-1:0]        best_yy;
        logic [TRACE_BITS-1:0]         max_eigen;
    } pmtfs_out_t;

    // One entry of the per-patch store.
    typedef struct packed {
        logic [TRACE_BITS-1:0]         trace;
        logic [TENSOR_BITS-1:0]        xx;
        logic signed [TENSOR_BITS-1:0] xy;
        logic [TENSOR_BITS-1:0]        yy;
        logic [COORD_BITS-1:0]         x;
        logic [COORD_BITS-1:0]         y;
    } pmtfs_entry_t;

    // Status of the eigenvalue unit.
    typedef struct packed {
        logic busy;
        logic done;
    } pmtfs_eig_stat_t;

    // Main sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EIGEN,
        ST_EMIT
    } pmtfs_state_t;

    // Eigenvalue unit states.
    typedef enum logic [2:0] {
        EIG_IDLE,
        EIG_PREP,
        EIG_MULT,
        EIG_SUM,
        EIG_ROOT,
        EIG_FINAL,
        EIG_DONE
    } pmtfs_eig_state_t;

endpackage

### rtl/core/pmtfs_eigen.sv
// Multi-cycle larger-eigenvalue unit with a bit-serial integer square root.
module pmtfs_eigen
    import pmtfs_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [TENSOR_BITS-1:0]        xx,
    input  logic signed [TENSOR_BITS-1:0] xy,
    input  logic [TENSOR_BITS-1:0]        yy,
    output pmtfs_eig_stat_t               stat,
    output logic [TRACE_BITS-1:0]         eigen
);

    pmtfs_eig_state_t state_reg, state_next;

    logic [TENSOR_BITS-1:0]        xx_reg, yy_reg;
    logic signed [TENSOR_BITS-1:0] xy_reg;
    logic [TENSOR_BITS-1:0]        diff_reg, mag_reg;
    logic [SQ_BITS-1:0]            dsq_reg, msq_reg;
    logic [RAD_BITS-1:0]           rad_reg;
    logic [REM_BITS-1:0]           rem_reg, rem_next;
    logic [ROOT_BITS-1:0]          root_reg, root_next;
    logic [ROOT_CNT_BITS-1:0]      cnt_reg;
    logic [TRACE_BITS-1:0]         eigen_reg;

    logic [REM_BITS-1:0]   rem_shift;
    logic [REM_BITS-1:0]   trial;
    logic                  root_bit;
    logic [TRACE_BITS+1:0] eig_sum;

    // One root digit per cycle: bring in two radicand bits and try the next root bit.
    always_comb begin
        rem_shift = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
        trial     = {root_reg, 2'b01};
        root_bit  = (rem_shift >= trial);
        rem_next  = root_bit ? (rem_shift - trial) : rem_shift;
        root_next = {root_reg[ROOT_BITS-2:0], root_bit};
        eig_sum   = (TRACE_BITS + 2)'(xx_reg) + (TRACE_BITS + 2)'(yy_reg)
                  + (TRACE_BITS + 2)'(root_reg);
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EIG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and status.
    always_comb begin
        state_next = state_reg;
        stat.busy  = (state_reg != EIG_IDLE);
        stat.done  = 1'b0;
        unique case (state_reg)
            EIG_IDLE: begin
                if (start) begin
                    state_next = EIG_PREP;
                end
            end
            EIG_PREP:  state_next = EIG_MULT;
            EIG_MULT:  state_next = EIG_SUM;
            EIG_SUM:   state_next = EIG_ROOT;
            EIG_ROOT: begin
                if (cnt_reg == ROOT_CNT_BITS'(ROOT_BITS - 1)) begin
                    state_next = EIG_FINAL;
                end
            end
            EIG_FINAL: state_next = EIG_DONE;
            EIG_DONE: begin
                stat.done  = 1'b1;
                state_next = EIG_IDLE;
            end
            default:   state_next = EIG_IDLE;
        endcase
    end

    // Datapath: absolute values, squares, discriminant, root, final halving.
    always_ff @(posedge aclk) begin
        case (state_reg)
            EIG_IDLE: begin
                if (start) begin
                    xx_reg <= xx;
                    xy_reg <= xy;
                    yy_reg <= yy;
                end
            end
            EIG_PREP: begin
                diff_reg <= (xx_reg >= yy_reg) ? (xx_reg - yy_reg) : (yy_reg - xx_reg);
                mag_reg  <= xy_reg[TENSOR_BITS-1] ? (~xy_reg + 1'b1) : xy_reg;
            end
            EIG_MULT: begin
                dsq_reg <= diff_reg * diff_reg;
                msq_reg <= mag_reg * mag_reg;
            end
            EIG_SUM: begin
                rad_reg  <= RAD_BITS'(dsq_reg) + (RAD_BITS'(msq_reg) << 2);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            EIG_ROOT: begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            EIG_FINAL: begin
                eigen_reg <= eig_sum[TRACE_BITS:1];
            end
            default: begin
            end
        endcase
    end

    assign eigen = eigen_reg;

endmodule

### rtl/core/patch_max_trace_feature_select_core.sv
// Top level of the per-patch max-trace feature selector with eigenvalue output.
//
//  Channel  Ports                       Direction  Carries
//  s_       s_valid s_ready s_data      in         one pixel request with its tensor
//  m_       m_valid m_ready m_data      out        best point of a finished patch
//
// A pixel that does not end its patch: the store is read on accept and, if the pixel
// is kept, written in the next cycle. A pixel that ends its patch also waits for the
// square-root iteration of the eigenvalue unit and the emit step before s_ready rises.
// Pixels with a patch number at or above MAX_PATCHES are accepted and dropped.
// Reset clears control state only; the store needs no clearing pass.
// A stalled result sits in the output register while the next pixel is taken.
module patch_max_trace_feature_select_core
    import pmtfs_pkg::*;
#(
    parameter int MAX_PATCHES = DEF_MAX_PATCHES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pmtfs_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pmtfs_out_t m_data
);

    localparam int ADDR_BITS = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;

    pmtfs_state_t state_reg, state_next;

    pmtfs_in_t    item_reg;
    pmtfs_entry_t rd_data_reg;
    pmtfs_entry_t best_reg;
    pmtfs_entry_t new_entry, chosen;
    pmtfs_entry_t mem [MAX_PATCHES];

    logic       m_valid_reg, m_valid_next;
    pmtfs_out_t m_data_reg;

    logic s_accept, in_range, take;
    logic mem_we, best_load, eig_start, out_load;

    pmtfs_eig_stat_t       eig_stat;
    logic [TRACE_BITS-1:0] eig_value;

    assign s_accept = s_valid && s_ready;
    assign in_range = (32'(s_data.patch_number) < MAX_PATCHES);

    // Candidate entry built from the held pixel, and the keep decision.
    always_comb begin
        new_entry.trace = TRACE_BITS'(item_reg.tensor_xx) + TRACE_BITS'(item_reg.tensor_yy);
        new_entry.xx    = item_reg.tensor_xx;
        new_entry.xy    = item_reg.tensor_xy;
        new_entry.yy    = item_reg.tensor_yy;
        new_entry.x     = item_reg.pixel_x;
        new_entry.y     = item_reg.pixel_y;
        take            = item_reg.first_of_patch || (new_entry.trace > rd_data_reg.trace);
        chosen          = take ? new_entry : rd_data_reg;
    end

    // Per-patch store: read on accept, written back during lookup.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= mem[ADDR_BITS'(s_data.patch_number)];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ADDR_BITS'(item_reg.patch_number)] <= new_entry;
        end
    end

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Sequencer: next state and strobes.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mem_we     = 1'b0;
        best_load  = 1'b0;
        eig_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && in_range) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                mem_we = take;
                if (item_reg.last_of_patch) begin
                    best_load  = 1'b1;
                    eig_start  = 1'b1;
                    state_next = ST_EIGEN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EIGEN: begin
                if (eig_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // Held pixel and chosen entry.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_data;
        end
        if (best_load) begin
            best_reg <= chosen;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.out_patch <= item_reg.patch_number;
            m_data_reg.point_x   <= best_reg.x;
            m_data_reg.point_y   <= best_reg.y;
            m_data_reg.best_xx   <= best_reg.xx;
            m_data_reg.best_xy   <= best_reg.xy;
            m_data_reg.best_yy   <= best_reg.yy;
            m_data_reg.max_eigen <= eig_value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Larger eigenvalue of the chosen tensor.
    pmtfs_eigen u_eigen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (eig_start),
        .xx      (chosen.xx),
        .xy      (chosen.xy),
        .yy      (chosen.yy),
        .stat    (eig_stat),
        .eigen   (eig_value)
    );

    // The eigenvalue unit is only started when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        eig_start |-> !eig_stat.busy)
        else $error("eigenvalue unit started while busy");

    // A finished eigenvalue always leads to the emit step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (eig_stat.done && state_reg == ST_EIGEN) |=> state_reg == ST_EMIT)
        else $error("eigenvalue result not followed by emit");

    // An out-of-range pixel leaves the store untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !in_range) |=> (state_reg == ST_IDLE && !mem_we))
        else $error("out-of-range pixel reached the store");

    // The output register is never overwritten while it holds an untaken result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule
